@@ src/assert_macros.svh @@
// Assertion macros shared by the encoder and button front end.
// No dependencies; taken in by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/ebf_pkg.sv @@
// Types, codes and constant tables of the encoder and button front end.
// No dependencies; imported by the button lane, the event ring and the front end.
`timescale 1ns / 1ps
package ebf_pkg;

	localparam int TIME_W = 32;
	localparam int DEB_W = 10;
	localparam int LP_W = 14;
	localparam int CNT_W = 16;
	localparam int CODE_W = 4;
	localparam int IN_BUTTONS = 4;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 10'd50;
	localparam logic [LP_W-1:0] LONG_PRESS_RESET = 14'd1000;
	localparam logic [1:0] QUAD_RESET = 2'd3;

	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_LONG_PRESS = 1'b1;

	localparam logic [CODE_W-1:0] EVT_NONE = 4'd0;
	localparam logic [CODE_W-1:0] EVT_CW = 4'd1;
	localparam logic [CODE_W-1:0] EVT_CCW = 4'd2;
	localparam logic [CODE_W-1:0] EVT_SHORT_BASE = 4'd3;
	localparam logic [CODE_W-1:0] EVT_LONG_BASE = 4'd4;

	// indexed by {previous pin pair, current pin pair}
	localparam logic signed [1:0] QUAD_DELTA [16] = '{
		2'sd0, -2'sd1, 2'sd1, 2'sd0,
		2'sd1, 2'sd0, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd1,
		2'sd0, 2'sd1, -2'sd1, 2'sd0
	};

	typedef struct packed {
		logic req_type;
		logic ms_tick;
		logic enc_a;
		logic enc_b;
		logic [IN_BUTTONS-1:0] button_levels;
	} ebf_in_t;

	typedef struct packed {
		logic [CODE_W-1:0] event_code;
		logic signed [CNT_W-1:0] encoder_pending;
	} ebf_out_t;

	typedef struct packed {
		logic eval;
		logic commit;
	} ebf_lane_ctl_t;

	typedef struct packed {
		logic push;
		logic is_long;
	} ebf_btn_req_t;

	typedef struct packed {
		logic valid;
		logic [CODE_W-1:0] code;
	} ebf_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ebf_ring_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_EVAL,
		ST_COMMIT,
		ST_PUSH,
		ST_POP,
		ST_FINISH
	} ebf_state_t;

	function automatic logic [CODE_W-1:0] ebf_btn_code(input logic [2:0] idx,
		input logic is_long);
		logic [CODE_W-1:0] base;
		base = is_long ? EVT_LONG_BASE : EVT_SHORT_BASE;
		return base + {idx, 1'b0};
	endfunction

endpackage

@@ src/ebf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ebf_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/ebf_btn_lane.sv @@
// One button lane: debounce, hold timing and press classification.
// Depends on ebf_pkg.
`timescale 1ns / 1ps
module ebf_btn_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ebf_pkg::ebf_lane_ctl_t       ctl,
	input  logic                         level,
	input  logic [ebf_pkg::TIME_W-1:0]   time_now,
	input  logic [ebf_pkg::DEB_W-1:0]    debounce_time,
	input  logic [ebf_pkg::LP_W-1:0]     long_press_time,
	output ebf_pkg::ebf_btn_req_t        req
);
	import ebf_pkg::*;

	logic              prev_q;
	logic              held_q;
	logic              long_done_q;
	logic [TIME_W-1:0] change_q;
	logic [TIME_W-1:0] hold_q;
	ebf_btn_req_t      req_q;
	logic              stable_s1;
	logic              long_s1;
	logic [TIME_W-1:0] since_change;
	logic [TIME_W-1:0] since_hold;

	assign since_change = (level != prev_q) ? '0 : time_now - change_q;
	assign since_hold = time_now - hold_q;

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			stable_s1 <= since_change > {{(TIME_W-DEB_W){1'b0}}, debounce_time};
			long_s1 <= since_hold >= {{(TIME_W-LP_W){1'b0}}, long_press_time};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b1;
			held_q <= 1'b0;
			long_done_q <= 1'b0;
			change_q <= '0;
			hold_q <= '0;
			req_q <= '0;
		end else if (ctl.commit) begin
			// short on release, long once the hold time is reached
			req_q <= {stable_s1 && held_q && !long_done_q && (level || long_s1), !level};
			if (level != prev_q) begin
				change_q <= time_now;
			end
			prev_q <= level;
			if (stable_s1) begin
				if (!level && !held_q) begin
					held_q <= 1'b1;
					long_done_q <= 1'b0;
					hold_q <= time_now;
				end else if (!level && held_q && !long_done_q) begin
					if (long_s1) begin
						long_done_q <= 1'b1;
					end
				end else if (level && held_q) begin
					held_q <= 1'b0;
				end
			end
		end
	end

	assign req = req_q;

endmodule

@@ src/ebf_event_ring.sv @@
// Event ring: head, tail and fill count around one RAM; drops pushes when full.
// Depends on ebf_pkg, ebf_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ebf_event_ring #(
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ebf_pkg::ebf_push_t           push,
	input  logic                         pop,
	output ebf_pkg::ebf_ring_stat_t      stat,
	output logic [ebf_pkg::CODE_W-1:0]   rd_code
);
	import ebf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] count_q;
	logic [PTR_W-1:0] used_w;
	logic             push_ok;
	logic             pop_ok;

	assign stat.empty = count_q == '0;
	assign stat.full = count_q == PTR_W'(DEPTH - 1);
	assign push_ok = push.valid && !stat.full;
	assign pop_ok = pop && !stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				head_q <= (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (pop_ok) begin
				tail_q <= (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	ebf_ram #(
		.WIDTH(CODE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (push_ok),
		.waddr(head_q),
		.wdata(push.code),
		.re   (pop_ok),
		.raddr(tail_q),
		.rdata(rd_code)
	);

	assign used_w = (head_q >= tail_q) ? head_q - tail_q
		: PTR_W'((PTR_W+1)'(head_q) + (PTR_W+1)'(DEPTH) - (PTR_W+1)'(tail_q));

	`ASSERT_IMPL(a_pop_nonempty, clk, arst_n, pop, !stat.empty)
	`ASSERT_IMPL(a_count_matches, clk, arst_n, 1'b1, count_q == used_w)

endmodule

@@ src/encoder_button_event_front_end.sv @@
// Encoder and button event front end: quadrature decode, button lanes, event ring.
// Sequencer and configuration registers live here.
// Depends on ebf_pkg, ebf_btn_lane, ebf_event_ring and assert_macros.svh.
//
// Every input word returns exactly one output word; the input side stays held until the
// word leaves its finish state, which loads the result. A sample-only word goes straight
// to finish. A poll word passes the drain, evaluate, commit, push and pop states first,
// where drain writes k detent events (k at most QUEUE_DEPTH-1) to the ring and push
// visits each button in turn: the ring has one write port, so detents and then button
// events enter it one per cycle. Button lanes evaluate in parallel (evaluate, commit).
// The result waits in an output register, so the next word is taken while it is
// pending; the last cycle of a word repeats while that register still holds an
// unaccepted word. Configuration registers sit on the APB port at byte addresses 0
// (debounce_time) and 4 (long_press_time).
`timescale 1ns / 1ps
`include "assert_macros.svh"
module encoder_button_event_front_end #(
	parameter int QUEUE_DEPTH = 16,
	parameter int NUM_BUTTONS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ebf_pkg::ebf_in_t             in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output ebf_pkg::ebf_out_t            out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ebf_pkg::ADDR_W-1:0]   paddr,
	input  logic [ebf_pkg::DATA_W-1:0]   pwdata,
	output logic [ebf_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import ebf_pkg::*;

	localparam int BTN_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	ebf_state_t               state_q;
	ebf_state_t               state_d;
	logic [DEB_W-1:0]         debounce_q;
	logic [LP_W-1:0]          long_press_q;
	logic [TIME_W-1:0]        time_q;
	logic [1:0]               quad_q;
	logic signed [CNT_W-1:0]  pending_q;
	logic [CNT_W-1:0]         mag_q;
	logic                     dir_ccw_q;
	logic [IN_BUTTONS-1:0]    levels_q;
	logic [BTN_W-1:0]         btn_q;
	logic                     pop_hit_q;
	logic                     out_valid_q;
	ebf_out_t                 out_data_q;

	logic                     accept;
	logic                     out_free;
	logic [1:0]               pair;
	logic signed [1:0]        delta;
	logic signed [CNT_W:0]    sum_w;
	logic signed [CNT_W-1:0]  sat_w;
	logic [CNT_W-1:0]         abs_w;
	logic                     btn_last;
	ebf_lane_ctl_t            lane_ctl;
	ebf_btn_req_t             lane_req [NUM_BUTTONS];
	ebf_btn_req_t             cur_req;
	ebf_push_t                push;
	logic                     pop;
	ebf_ring_stat_t           ring_stat;
	logic [CODE_W-1:0]        ring_code;

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_DEBOUNCE: debounce_q <= pwdata[DEB_W-1:0];
				REG_LONG_PRESS: long_press_q <= pwdata[LP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DEBOUNCE: prdata = {{(DATA_W-DEB_W){1'b0}}, debounce_q};
			REG_LONG_PRESS: prdata = {{(DATA_W-LP_W){1'b0}}, long_press_q};
			default: prdata = '0;
		endcase
	end

	// Quadrature decode and saturating count
	assign pair = {in_data.enc_a, in_data.enc_b};
	assign delta = QUAD_DELTA[{quad_q, pair}];
	assign sum_w = {pending_q[CNT_W-1], pending_q} + {{(CNT_W-1){delta[1]}}, delta};
	assign sat_w = (sum_w[CNT_W] != sum_w[CNT_W-1])
		? {sum_w[CNT_W], {(CNT_W-1){!sum_w[CNT_W]}}} : sum_w[CNT_W-1:0];
	assign abs_w = sat_w[CNT_W-1] ? $unsigned(~sat_w) + 1'b1 : $unsigned(sat_w);

	assign in_ready = state_q == ST_IDLE;
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign btn_last = btn_q == BTN_W'(NUM_BUTTONS - 1);
	assign cur_req = lane_req[btn_q];

	// Button lanes
	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		logic lane_level;
		if (i < IN_BUTTONS) begin : g_pin
			assign lane_level = levels_q[i];
		end else begin : g_idle
			assign lane_level = 1'b1;
		end
		ebf_btn_lane u_lane (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (lane_ctl),
			.level          (lane_level),
			.time_now       (time_q),
			.debounce_time  (debounce_q),
			.long_press_time(long_press_q),
			.req            (lane_req[i])
		);
	end

	ebf_event_ring #(
		.DEPTH(QUEUE_DEPTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.stat   (ring_stat),
		.rd_code(ring_code)
	);

	// Sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = in_data.req_type ? ST_DRAIN : ST_FINISH;
				end
			end
			ST_DRAIN: begin
				if (mag_q == '0 || ring_stat.full) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_PUSH;
			ST_PUSH: begin
				if (btn_last) begin
					state_d = ST_POP;
				end
			end
			ST_POP: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		lane_ctl = '0;
		push = '0;
		pop = 1'b0;
		case (state_q)
			ST_DRAIN: begin
				push.valid = mag_q != '0 && !ring_stat.full;
				push.code = dir_ccw_q ? EVT_CCW : EVT_CW;
			end
			ST_EVAL: lane_ctl.eval = 1'b1;
			ST_COMMIT: lane_ctl.commit = 1'b1;
			ST_PUSH: begin
				push.valid = cur_req.push;
				push.code = ebf_btn_code(3'(btn_q), cur_req.is_long);
			end
			ST_POP: pop = !ring_stat.empty;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			time_q <= '0;
			quad_q <= QUAD_RESET;
			pending_q <= '0;
			mag_q <= '0;
			dir_ccw_q <= 1'b0;
			btn_q <= '0;
			pop_hit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				time_q <= time_q + {{(TIME_W-1){1'b0}}, in_data.ms_tick};
				quad_q <= pair;
				pending_q <= in_data.req_type ? '0 : sat_w;
				mag_q <= in_data.req_type ? abs_w : '0;
				dir_ccw_q <= sat_w[CNT_W-1];
				pop_hit_q <= 1'b0;
				btn_q <= '0;
			end
			if (state_q == ST_DRAIN && push.valid) begin
				mag_q <= mag_q - 1'b1;
			end
			if (state_q == ST_PUSH && !btn_last) begin
				btn_q <= btn_q + 1'b1;
			end
			if (state_q == ST_POP) begin
				pop_hit_q <= pop;
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			levels_q <= in_data.button_levels;
		end
		if (state_q == ST_FINISH && out_free) begin
			out_data_q.event_code <= pop_hit_q ? ring_code : EVT_NONE;
			out_data_q.encoder_pending <= pending_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	`ASSERT_IMPL(a_result_from_finish, clk, arst_n, $rose(out_valid_q),
		$past(state_q) == ST_FINISH)
	`ASSERT_NEXT(a_drain_counts_down, clk, arst_n,
		state_q == ST_DRAIN && mag_q != '0 && !ring_stat.full,
		mag_q == $past(mag_q) - 16'd1)
	`ASSERT_IMPL(a_poll_clears_count, clk, arst_n, state_q == ST_POP, pending_q == '0)

endmodule
